@@ rtl/lpnsc_pkg.sv @@
package lpnsc_pkg;

  localparam int PREFIX_DEPTH     = 48;
  localparam int SAMPLE_SIZE_BITS = 24;
  localparam int PIDX_W           = $clog2(PREFIX_DEPTH);
  localparam int PLEN_W           = $clog2(PREFIX_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_LEN_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODEC    = 2'd1;

  // delimiter insert: 00 00 00 01 09 F0, unit start code: 00 00 01
  localparam int          AUD_LEN       = 6;
  localparam int          SC_LEN        = 3;
  localparam int          PSET_SC_LEN   = 4;
  localparam logic [7:0]  NAL_TYPE_MASK = 8'h1F;
  localparam logic [7:0]  AUD_NAL_TYPE  = 8'd9;
  localparam logic [7:0]  AUD_PAYLOAD   = 8'hF0;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SAMPLE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_TRUNC  = 2'd1,
    ST_OVFL   = 2'd2,
    ST_BADLEN = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_READ = 2'd0,
    PH_COPY = 2'd1,
    PH_DROP = 2'd2
  } phase_e;

  // order matters: segments are played out in increasing code order
  typedef enum logic [2:0] {
    SEG_IDLE = 3'd0,
    SEG_WR   = 3'd1,
    SEG_AUD  = 3'd2,
    SEG_PFX1 = 3'd3,
    SEG_SC   = 3'd4,
    SEG_BYTE = 3'd5,
    SEG_PFX2 = 3'd6,
    SEG_STAT = 3'd7
  } seg_e;

  typedef struct packed {
    logic [1:0]                  opcode;
    logic [7:0]                  data_byte;
    logic                        first_byte;
    logic                        last_byte;
    logic                        key_frame;
    logic [SAMPLE_SIZE_BITS-1:0] sample_size;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       sample_done;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic wr;
    logic wr_first;
    logic aud;
    logic pfx1;
    logic sc;
    logic byte_en;
    logic pfx2;
    logic stat;
    logic done;
  } plan_t;

  typedef struct packed {
    logic              accept;
    logic              load;
    logic              last;
    logic              wr;
    seg_e              seg;
    logic [PIDX_W-1:0] idx;
    logic [PIDX_W-1:0] raddr;
  } cmd_t;

  typedef struct packed {
    plan_t             plan;
    plan_t             plan_acc;
    logic [PLEN_W-1:0] plen;
  } stat_t;

  function automatic seg_e next_seg(plan_t p, seg_e cur);
    seg_e s;
    s = SEG_IDLE;
    if (cur < SEG_STAT && p.stat) s = SEG_STAT;
    if (cur < SEG_PFX2 && p.pfx2) s = SEG_PFX2;
    if (cur < SEG_BYTE && p.byte_en) s = SEG_BYTE;
    if (cur < SEG_SC && p.sc) s = SEG_SC;
    if (cur < SEG_PFX1 && p.pfx1) s = SEG_PFX1;
    if (cur < SEG_AUD && p.aud) s = SEG_AUD;
    if (cur < SEG_WR && p.wr) s = SEG_WR;
    return s;
  endfunction

  function automatic logic [7:0] aud_byte(logic [PIDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      PIDX_W'(3): b = 8'h01;
      PIDX_W'(4): b = AUD_NAL_TYPE;
      PIDX_W'(5): b = AUD_PAYLOAD;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] sc_byte(logic [PIDX_W-1:0] idx);
    return (idx == PIDX_W'(SC_LEN - 1)) ? 8'h01 : 8'h00;
  endfunction

endpackage

@@ rtl/length_prefixed_nal_to_start_code.sv @@
// Converts length-prefixed NAL samples to a start-code stream, one result beat per cycle
// while the output is not stalled. The next item is taken in the same cycle its
// predecessor's last beat enters the output register. A unit head adds the start code
// (00 00 01), an inserted delimiter 00 00 00 01 09 F0, and a stored prefix its bytes,
// read from the 48-entry prefix store through its single registered read port. A
// parameter-set append occupies the store's single write port for the set byte, on the
// first byte of a set with the start code 00 00 00 01 written first, during which no
// item is taken. Output stalls hold the sequencer in place except while a set is written.
module length_prefixed_nal_to_start_code (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  lpnsc_pkg::in_t                     in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output lpnsc_pkg::out_t                    out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lpnsc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lpnsc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import lpnsc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  lpnsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lpnsc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/lpnsc_dp.sv @@
module lpnsc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lpnsc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lpnsc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  lpnsc_pkg::in_t                      in_data_i,
  input  lpnsc_pkg::cmd_t                     cmd_i,
  output lpnsc_pkg::stat_t                    stat_o,
  output lpnsc_pkg::out_t                     out_data_o
);
  import lpnsc_pkg::*;

  logic [2:0]                  lsize_q;
  logic                        avc_q;
  logic [PLEN_W-1:0]           plen_q, plen_d;
  logic [31:0]                 acc_q, acc_d;
  logic [2:0]                  seen_q, seen_d;
  logic [SAMPLE_SIZE_BITS-1:0] sleft_q, sleft_d;
  logic [31:0]                 uleft_q, uleft_d;
  phase_e                      ph_q, ph_d;
  logic                        fu_q, fu_d;
  logic                        pend_q, pend_d;
  plan_t                       plan_q;
  logic [7:0]                  byte_q;
  logic [1:0]                  err_q;
  out_t                        out_q, out_d;

  logic [7:0]                  pfx_mem [PREFIX_DEPTH];
  logic [7:0]                  rd_q;
  logic [7:0]                  wdata;

  // combinational step of one accepted item
  plan_t                       plan_w;
  logic [1:0]                  err_w;
  logic [PLEN_W:0]             fill_w;
  logic                        open_w, end_w, size_ok_w, avc_first_w;
  logic                        head_w, have_byte_w, unit_done_w;
  logic [SAMPLE_SIZE_BITS-1:0] sz_w, sl_w, sl_m1_w, rem_w;
  logic [31:0]                 acc_w, ul_w;
  logic [2:0]                  seen_w;
  phase_e                      ph_w;
  logic                        fu_w, pend_w;
  logic                        pfx_any_w;

  assign pfx_any_w = (plen_q != '0);

  always_comb begin
    plan_w      = '0;
    err_w       = ST_OK;
    fill_w      = {1'b0, plen_q} + (in_data_i.first_byte ? (PLEN_W + 1)'(PSET_SC_LEN + 1)
                                                          : (PLEN_W + 1)'(1));
    open_w      = in_data_i.first_byte || (sleft_q != '0);
    sz_w        = in_data_i.sample_size;
    head_w      = 1'b0;
    have_byte_w = 1'b0;
    unit_done_w = 1'b0;
    size_ok_w   = (lsize_q == 3'd1) || (lsize_q == 3'd2) || (lsize_q == 3'd4);

    if (in_data_i.first_byte) begin
      sl_w   = (sz_w == '0) ? SAMPLE_SIZE_BITS'(1) : sz_w;
      pend_w = in_data_i.key_frame;
      fu_w   = 1'b1;
      ph_w   = PH_READ;
      seen_w = '0;
      acc_w  = '0;
      ul_w   = '0;
    end else begin
      sl_w   = sleft_q;
      pend_w = pend_q;
      fu_w   = fu_q;
      ph_w   = ph_q;
      seen_w = seen_q;
      acc_w  = acc_q;
      ul_w   = uleft_q;
    end

    sl_m1_w     = sl_w - SAMPLE_SIZE_BITS'(1);
    end_w       = in_data_i.last_byte || (sl_m1_w == '0);
    rem_w       = end_w ? '0 : sl_m1_w;
    avc_first_w = avc_q && fu_w;

    case (ph_w)
      PH_READ: begin
        if (seen_w == '0 && !size_ok_w) begin
          err_w = ST_BADLEN;
          ph_w  = PH_DROP;
        end else begin
          acc_w  = {((seen_w == '0) ? 24'd0 : acc_w[23:0]), in_data_i.data_byte};
          seen_w = seen_w + 3'd1;
          if (seen_w >= lsize_q) begin
            seen_w = '0;
            if (acc_w > 32'(rem_w)) begin
              err_w = ST_TRUNC;
              ph_w  = PH_DROP;
            end else if (acc_w == '0) begin
              head_w = 1'b1;
            end else begin
              ul_w = acc_w;
              ph_w = PH_COPY;
            end
          end
        end
      end
      PH_COPY: begin
        head_w         = (ul_w == acc_w);
        have_byte_w    = 1'b1;
        plan_w.byte_en = 1'b1;
        ul_w           = ul_w - 32'd1;
        if (ul_w == '0) begin
          unit_done_w = 1'b1;
          ph_w        = PH_READ;
        end
      end
      default: ;
    endcase

    if (head_w) begin
      if (avc_first_w) begin
        // a leading delimiter defers the prefix to the end of that unit
        if (!(have_byte_w &&
              ((in_data_i.data_byte & NAL_TYPE_MASK) == AUD_NAL_TYPE))) begin
          plan_w.aud  = 1'b1;
          plan_w.pfx1 = pend_w && pfx_any_w;
          pend_w      = pend_w ? 1'b0 : pend_w;
        end
      end else begin
        plan_w.pfx1 = pend_w && pfx_any_w;
        pend_w      = 1'b0;
      end
      plan_w.sc = 1'b1;
      fu_w      = 1'b0;
    end

    if (unit_done_w && pend_w) begin
      plan_w.pfx2 = pfx_any_w;
      pend_w      = 1'b0;
    end

    if (end_w) begin
      if (err_w == ST_OK && (ph_w == PH_COPY || (ph_w == PH_READ && seen_w != '0))) begin
        err_w = ST_TRUNC;
      end
      sl_m1_w = '0;
      ul_w    = '0;
      seen_w  = '0;
      ph_w    = PH_READ;
      fu_w    = 1'b1;
      pend_w  = 1'b0;
    end

    plan_w.stat = (err_w != ST_OK) ||
                  (end_w && !(plan_w.aud || plan_w.pfx1 || plan_w.sc ||
                              plan_w.byte_en || plan_w.pfx2));
    plan_w.done = end_w;

    case (in_data_i.opcode)
      OP_APPEND: begin
        plan_w = '0;
        if (fill_w > (PLEN_W + 1)'(PREFIX_DEPTH)) begin
          plan_w.stat = 1'b1;
          err_w       = ST_OVFL;
        end else begin
          plan_w.wr       = 1'b1;
          plan_w.wr_first = in_data_i.first_byte;
          err_w           = ST_OK;
        end
      end
      OP_SAMPLE: begin
        if (!open_w) begin
          plan_w = '0;
        end
      end
      default: begin
        plan_w = '0;
        err_w  = ST_OK;
      end
    endcase
  end

  always_comb begin
    plen_d  = plen_q;
    acc_d   = acc_q;
    seen_d  = seen_q;
    sleft_d = sleft_q;
    uleft_d = uleft_q;
    ph_d    = ph_q;
    fu_d    = fu_q;
    pend_d  = pend_q;
    if (cmd_i.wr) begin
      plen_d = plen_q + PLEN_W'(1);
    end
    if (cmd_i.accept) begin
      if (in_data_i.opcode == OP_CLEAR) begin
        plen_d = '0;
      end else if (in_data_i.opcode == OP_SAMPLE && open_w) begin
        acc_d   = acc_w;
        seen_d  = seen_w;
        sleft_d = sl_m1_w;
        uleft_d = ul_w;
        ph_d    = ph_w;
        fu_d    = fu_w;
        pend_d  = pend_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsize_q <= 3'd4;
      avc_q   <= 1'b1;
      plen_q  <= '0;
      acc_q   <= '0;
      seen_q  <= '0;
      sleft_q <= '0;
      uleft_q <= '0;
      ph_q    <= PH_READ;
      fu_q    <= 1'b1;
      pend_q  <= 1'b0;
      plan_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LEN_SIZE: lsize_q <= cfg_wdata_i;
          CFG_CODEC:    avc_q   <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      plen_q  <= plen_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      sleft_q <= sleft_d;
      uleft_q <= uleft_d;
      ph_q    <= ph_d;
      fu_q    <= fu_d;
      pend_q  <= pend_d;
      if (cmd_i.accept) begin
        plan_q <= plan_w;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= in_data_i.data_byte;
      err_q  <= err_w;
    end
  end

  // parameter-set writer: 00 00 00 01 then the set byte, one entry per cycle
  always_comb begin
    if (cmd_i.idx < PIDX_W'(PSET_SC_LEN - 1)) begin
      wdata = 8'h00;
    end else if (cmd_i.idx == PIDX_W'(PSET_SC_LEN - 1)) begin
      wdata = 8'h01;
    end else begin
      wdata = byte_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      pfx_mem[plen_q[PIDX_W-1:0]] <= wdata;
    end
    rd_q <= pfx_mem[cmd_i.raddr];
  end

  always_comb begin
    out_d             = '0;
    out_d.run_last    = cmd_i.last;
    out_d.sample_done = cmd_i.last && plan_q.done;
    case (cmd_i.seg)
      SEG_AUD: begin
        out_d.out_byte   = aud_byte(cmd_i.idx);
        out_d.byte_valid = 1'b1;
      end
      SEG_PFX1, SEG_PFX2: begin
        out_d.out_byte   = rd_q;
        out_d.byte_valid = 1'b1;
      end
      SEG_SC: begin
        out_d.out_byte   = sc_byte(cmd_i.idx);
        out_d.byte_valid = 1'b1;
      end
      SEG_BYTE: begin
        out_d.out_byte   = byte_q;
        out_d.byte_valid = 1'b1;
      end
      SEG_STAT: begin
        out_d.status = err_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o      = out_q;
  assign stat_o.plan     = plan_q;
  assign stat_o.plan_acc = plan_w;
  assign stat_o.plen     = plen_q;

endmodule

@@ rtl/lpnsc_ctrl.sv @@
module lpnsc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  lpnsc_pkg::stat_t   stat_i,
  output lpnsc_pkg::cmd_t    cmd_o
);
  import lpnsc_pkg::*;

  seg_e              state_q, state_d;
  logic [PIDX_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;

  seg_e              nxt, first;
  logic              load_ok, res_seg, seg_end, emit, last, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEG_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    load_ok = !out_valid_q || !out_stall_i;
    nxt     = next_seg(stat_i.plan, state_q);
    first   = next_seg(stat_i.plan_acc, SEG_IDLE);

    case (state_q)
      SEG_AUD:            seg_end = (cnt_q == PIDX_W'(AUD_LEN - 1));
      SEG_SC:             seg_end = (cnt_q == PIDX_W'(SC_LEN - 1));
      SEG_PFX1, SEG_PFX2: seg_end = (PLEN_W'(cnt_q) == stat_i.plen - PLEN_W'(1));
      SEG_WR:             seg_end = (cnt_q == PIDX_W'(PSET_SC_LEN));
      SEG_BYTE, SEG_STAT: seg_end = 1'b1;
      default:            seg_end = 1'b0;
    endcase

    res_seg = (state_q != SEG_IDLE) && (state_q != SEG_WR);
    emit    = res_seg && load_ok;
    last    = seg_end && (nxt == SEG_IDLE);

    // next item enters when idle, or as the current one's final beat goes into the output register
    in_stall_o = !((state_q == SEG_IDLE) || (emit && last));
    accept     = in_valid_i && !in_stall_o;

    state_d = state_q;
    cnt_d   = cnt_q;
    if (state_q == SEG_WR) begin
      if (seg_end) begin
        state_d = SEG_IDLE;
        cnt_d   = '0;
      end else begin
        cnt_d = cnt_q + PIDX_W'(1);
      end
    end else if (emit) begin
      if (seg_end) begin
        state_d = nxt;
        cnt_d   = '0;
      end else begin
        cnt_d = cnt_q + PIDX_W'(1);
      end
    end
    if (accept) begin
      state_d = first;
      cnt_d   = (first == SEG_WR && !stat_i.plan_acc.wr_first) ? PIDX_W'(PSET_SC_LEN) : '0;
    end

    out_valid_d = emit || (out_valid_q && out_stall_i);

    cmd_o.accept = accept;
    cmd_o.load   = emit;
    cmd_o.last   = last;
    cmd_o.wr     = (state_q == SEG_WR);
    cmd_o.seg    = state_q;
    cmd_o.idx    = cnt_q;
    cmd_o.raddr  = cnt_d;
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_pfx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEG_PFX1 || state_q == SEG_PFX2) |-> (PLEN_W'(cnt_q) < stat_i.plen))
    else $error("prefix read index beyond stored prefix");

  a_wr_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEG_WR) |-> (stat_i.plen < PLEN_W'(PREFIX_DEPTH)))
    else $error("prefix write beyond store depth");

  a_aud_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEG_AUD || state_q == SEG_SC) |-> (cnt_q < PIDX_W'(AUD_LEN)))
    else $error("insert counter overrun");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last && !accept) |=> (state_q == SEG_IDLE && out_valid_q))
    else $error("sequencer did not close run after last beat");
`endif

endmodule
